// ===== rtl/pec_pkg.sv =====
package pec_pkg;

   localparam int NUM_CNT   = 16;
   localparam int CNT_IDX_W = 4;
   localparam int INC_W     = 22;   // widest single-item increment (access cycle charge)
   localparam int CFG_W     = 16;
   localparam int CSR_IDX_W = 4;
   localparam int RSP_W     = 64;

   // event opcodes
   localparam logic [3:0] OP_FETCH      = 4'd0;
   localparam logic [3:0] OP_READ       = 4'd1;
   localparam logic [3:0] OP_WRITE      = 4'd2;
   localparam logic [3:0] OP_TLB_HIT    = 4'd3;
   localparam logic [3:0] OP_TLB_MISS   = 4'd4;
   localparam logic [3:0] OP_RETIRE     = 4'd5;
   localparam logic [3:0] OP_EXC_FLUSH  = 4'd6;
   localparam logic [3:0] OP_READ_CNT   = 4'd7;
   localparam logic [3:0] OP_CLEAR      = 4'd8;

   // counter slots
   localparam logic [CNT_IDX_W-1:0] IX_CYCLES    = 4'd0;
   localparam logic [CNT_IDX_W-1:0] IX_RETIRED   = 4'd1;
   localparam logic [CNT_IDX_W-1:0] IX_FLUSHES   = 4'd2;
   localparam logic [CNT_IDX_W-1:0] IX_STALLS    = 4'd3;
   localparam logic [CNT_IDX_W-1:0] IX_FETCHES   = 4'd4;
   localparam logic [CNT_IDX_W-1:0] IX_READS     = 4'd5;
   localparam logic [CNT_IDX_W-1:0] IX_WRITES    = 4'd6;
   localparam logic [CNT_IDX_W-1:0] IX_IHITS     = 4'd7;
   localparam logic [CNT_IDX_W-1:0] IX_IMISSES   = 4'd8;
   localparam logic [CNT_IDX_W-1:0] IX_DHITS     = 4'd9;
   localparam logic [CNT_IDX_W-1:0] IX_DMISSES   = 4'd10;
   localparam logic [CNT_IDX_W-1:0] IX_EVICTS    = 4'd11;
   localparam logic [CNT_IDX_W-1:0] IX_TLBHITS   = 4'd12;
   localparam logic [CNT_IDX_W-1:0] IX_TLBMISSES = 4'd13;
   localparam logic [CNT_IDX_W-1:0] IX_BRANCHES  = 4'd14;
   localparam logic [CNT_IDX_W-1:0] IX_REDIRECTS = 4'd15;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_HIT_COST      = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MISS_PENALTY  = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_EVICT_PENALTY = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TLB_PENALTY   = 4'd3;

   typedef struct packed {
      logic [3:0]  opcode;
      logic [3:0]  line_hits;
      logic [3:0]  line_misses;
      logic [3:0]  dirty_evicts;
      logic        is_control_flow;
      logic        was_redirected;
      logic [15:0] step_total_cycles;
      logic [15:0] step_stall_cycles;
      logic        step_flushed;
      logic [3:0]  counter_select;
   } item_type;

   typedef struct packed {
      logic [CFG_W-1:0] hit_cost;
      logic [CFG_W-1:0] miss_penalty;
      logic [CFG_W-1:0] evict_penalty;
      logic [CFG_W-1:0] tlb_penalty;
   } cfg_type;

   typedef struct packed {
      logic                 read;
      logic                 clear;
      logic [CNT_IDX_W-1:0] sel;
   } bank_ctrl_type;

   typedef logic [INC_W-1:0] incr_type;

endpackage

// ===== rtl/pec_incr.sv =====
module pec_incr
   import pec_pkg::*;
(
   input  item_type      item,
   input  cfg_type       cfg,
   output incr_type      incr [NUM_CNT],
   output bank_ctrl_type ctrl
);

   logic [19:0]      hit_part;
   logic [20:0]      miss_part;
   logic [19:0]      evict_part;
   logic [20:0]      miss_stall;
   logic [INC_W-1:0] access_total;
   logic [20:0]      access_stall;

   always_comb begin
      hit_part     = 20'(item.line_hits) * 20'(cfg.hit_cost);
      miss_part    = 21'(item.line_misses)
                   * (21'(cfg.hit_cost) + 21'(cfg.miss_penalty));
      evict_part   = 20'(item.dirty_evicts) * 20'(cfg.evict_penalty);
      miss_stall   = 21'(item.line_misses) * 21'(cfg.miss_penalty);
      access_total = INC_W'(hit_part) + INC_W'(miss_part) + INC_W'(evict_part);
      access_stall = miss_stall + 21'(evict_part);
   end

   always_comb begin
      for (int i = 0; i < NUM_CNT; i++) begin
         incr[i] = '0;
      end
      ctrl.read  = 1'b0;
      ctrl.clear = 1'b0;
      ctrl.sel   = item.counter_select;

      case (item.opcode)
         OP_FETCH, OP_READ, OP_WRITE: begin
            if (item.opcode == OP_FETCH) begin
               incr[IX_FETCHES] = INC_W'(1);
               incr[IX_IHITS]   = INC_W'(item.line_hits);
               incr[IX_IMISSES] = INC_W'(item.line_misses);
            end else begin
               if (item.opcode == OP_READ) begin
                  incr[IX_READS] = INC_W'(1);
               end else begin
                  incr[IX_WRITES] = INC_W'(1);
               end
               incr[IX_DHITS]   = INC_W'(item.line_hits);
               incr[IX_DMISSES] = INC_W'(item.line_misses);
            end
            incr[IX_EVICTS] = INC_W'(item.dirty_evicts);
            incr[IX_CYCLES] = access_total;
            incr[IX_STALLS] = INC_W'(access_stall);
         end
         OP_TLB_HIT: begin
            incr[IX_TLBHITS] = INC_W'(1);
         end
         OP_TLB_MISS: begin
            incr[IX_TLBMISSES] = INC_W'(1);
            incr[IX_STALLS]    = INC_W'(cfg.tlb_penalty);
            incr[IX_CYCLES]    = INC_W'(cfg.tlb_penalty);
         end
         OP_RETIRE: begin
            incr[IX_RETIRED]   = INC_W'(1);
            incr[IX_CYCLES]    = INC_W'(item.step_total_cycles);
            incr[IX_STALLS]    = INC_W'(item.step_stall_cycles);
            incr[IX_FLUSHES]   = INC_W'(item.step_flushed);
            incr[IX_BRANCHES]  = INC_W'(item.is_control_flow);
            // a redirect only counts on a branch
            incr[IX_REDIRECTS] = INC_W'(item.is_control_flow & item.was_redirected);
         end
         OP_EXC_FLUSH: begin
            incr[IX_CYCLES]  = INC_W'(item.step_total_cycles);
            incr[IX_STALLS]  = INC_W'(item.step_stall_cycles);
            incr[IX_FLUSHES] = INC_W'(1);
         end
         OP_READ_CNT: begin
            ctrl.read = 1'b1;
         end
         OP_CLEAR: begin
            ctrl.clear = 1'b1;
         end
         default: begin
            ctrl.read = 1'b0;
         end
      endcase
   end

endmodule

// ===== rtl/pec_bank.sv =====
module pec_bank
   import pec_pkg::*;
#(
   parameter int COUNTER_WIDTH = 64
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  incr_type                 incr [NUM_CNT],
   input  bank_ctrl_type            ctrl,
   output logic [COUNTER_WIDTH-1:0] read_data
);

   logic [COUNTER_WIDTH-1:0] counters_ff [NUM_CNT];
   logic [COUNTER_WIDTH-1:0] counters_in [NUM_CNT];

   always_comb begin
      for (int i = 0; i < NUM_CNT; i++) begin
         if (ctrl.clear) begin
            counters_in[i] = '0;
         end else begin
            // wraps at the counter width
            counters_in[i] = counters_ff[i] + COUNTER_WIDTH'(incr[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CNT; i++) begin
            counters_ff[i] <= '0;
         end
      end else if (en) begin
         counters_ff <= counters_in;
      end
   end

   assign read_data = counters_ff[ctrl.sel];

endmodule

// ===== rtl/perf_event_counter_bank.sv =====
// Path: an accepted item is held in the input register; when the result register is free
// or being drained, the item's result is loaded there and rsp_valid rises with it.
// Throughput: one item per cycle unless a full result register stalls; the counter bank
// updates all sixteen counters in the cycle an item leaves the input register.
// Reset: synchronous; clears every counter, empties both registers and loads the cost
// registers with hit cost 1 and all penalties 0.
module perf_event_counter_bank
   import pec_pkg::*;
#(
   parameter int COUNTER_WIDTH = 64
)
(
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [3:0]           req_opcode,
   input  logic [3:0]           req_line_hits,
   input  logic [3:0]           req_line_misses,
   input  logic [3:0]           req_dirty_evicts,
   input  logic                 req_is_control_flow,
   input  logic                 req_was_redirected,
   input  logic [15:0]          req_step_total_cycles,
   input  logic [15:0]          req_step_stall_cycles,
   input  logic                 req_step_flushed,
   input  logic [3:0]           req_counter_select,

   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [RSP_W-1:0]     rsp_counter_value,

   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wr_data
);

   item_type                 item_ff, item_in;
   logic                     item_valid_ff, item_valid_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]         rsp_value_ff, rsp_value_in;
   cfg_type                  cfg_ff, cfg_in;

   logic                     req_accept;
   logic                     adv;
   incr_type                 incr [NUM_CNT];
   bank_ctrl_type            ctrl;
   logic [COUNTER_WIDTH-1:0] read_data;

   // move the held item on whenever the result register is free or being drained
   assign adv        = item_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !item_valid_ff || adv;
   assign req_accept = req_valid && req_ready;

   always_comb begin
      item_in = item_ff;
      if (req_accept) begin
         item_in.opcode            = req_opcode;
         item_in.line_hits         = req_line_hits;
         item_in.line_misses       = req_line_misses;
         item_in.dirty_evicts      = req_dirty_evicts;
         item_in.is_control_flow   = req_is_control_flow;
         item_in.was_redirected    = req_was_redirected;
         item_in.step_total_cycles = req_step_total_cycles;
         item_in.step_stall_cycles = req_step_stall_cycles;
         item_in.step_flushed      = req_step_flushed;
         item_in.counter_select    = req_counter_select;
      end
   end

   always_comb begin
      if (req_accept) begin
         item_valid_in = 1'b1;
      end else if (adv) begin
         item_valid_in = 1'b0;
      end else begin
         item_valid_in = item_valid_ff;
      end
   end

   always_comb begin
      if (adv) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = ctrl.read ? RSP_W'(read_data) : '0;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_ready;
         rsp_value_in = rsp_value_ff;
      end
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_HIT_COST:      cfg_in.hit_cost      = csr_wr_data;
            CSR_MISS_PENALTY:  cfg_in.miss_penalty  = csr_wr_data;
            CSR_EVICT_PENALTY: cfg_in.evict_penalty = csr_wr_data;
            CSR_TLB_PENALTY:   cfg_in.tlb_penalty   = csr_wr_data;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff        <= 1'b0;
         rsp_valid_ff         <= 1'b0;
         cfg_ff.hit_cost      <= CFG_W'(1);
         cfg_ff.miss_penalty  <= '0;
         cfg_ff.evict_penalty <= '0;
         cfg_ff.tlb_penalty   <= '0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         cfg_ff        <= cfg_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff      <= item_in;
      rsp_value_ff <= rsp_value_in;
   end

   pec_incr u_incr (
      .item (item_ff),
      .cfg  (cfg_ff),
      .incr (incr),
      .ctrl (ctrl)
   );

   pec_bank #(
      .COUNTER_WIDTH (COUNTER_WIDTH)
   ) u_bank (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .incr      (incr),
      .ctrl      (ctrl),
      .read_data (read_data)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_counter_value = rsp_value_ff;

   a_adv_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      adv |=> rsp_valid)
      else $error("item advanced but no result presented");

   a_no_bubble: assert property (@(posedge clock) disable iff (reset)
      item_valid_ff && !rsp_valid_ff |-> adv)
      else $error("held item stalled with result register empty");

   a_non_read_zero: assert property (@(posedge clock) disable iff (reset)
      adv && item_ff.opcode != OP_READ_CNT |=> rsp_counter_value == '0)
      else $error("non-read item returned a nonzero value");

   a_read_after_clear: assert property (@(posedge clock) disable iff (reset)
      adv && item_ff.opcode == OP_CLEAR ##1 adv && item_ff.opcode == OP_READ_CNT
      |=> rsp_counter_value == '0)
      else $error("read straight after clear returned a nonzero value");

endmodule
